// File: src/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types, constants and helpers for the shading frame transform.
// ----------------------------------------------------------------------------
package sft_pkg;

    localparam int FRAC_BITS_DEF = 14;  // Q1.14 by default
    localparam int DW            = 16;  // port data width
    localparam int NB            = 20;  // magnitude bits kept before normalizing
    localparam int NORM_SH       = 10;  // extra scale on the length
    localparam int SQ_W          = 3 * NB + 2;  // width of sum of squares << NB
    localparam int SQ_STEPS      = SQ_W / 2;    // one root bit per step
    localparam int RT_W          = SQ_W / 2;    // root width
    localparam int MAG_W         = 34;          // widest magnitude fed to sign_sat
    localparam int TW            = DW + 2;      // raw tangent width
    localparam int RRW           = 2 * DW + 2;  // raw result width

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic op;
        vec_t n;
        vec_t v;
    } in_ctx_t;

    typedef struct packed {
        vec_t t;
        vec_t b;
        logic zero;
    } out_ctx_t;

    // clamp a magnitude to lim and apply the sign
    function automatic logic signed [DW-1:0] sign_sat(
        input logic [MAG_W-1:0] mag,
        input logic             neg,
        input logic [DW-1:0]    lim
    );
        logic [DW-1:0] m;
        m = (mag > MAG_W'(lim)) ? lim : mag[DW-1:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: src/sft_norm.sv
// ----------------------------------------------------------------------------
// sft_norm
// Pipelined 3-vector normalizer: range reduce, sum of squares, bit-per-stage
// square root, bit-per-stage division of each lane, then sign and clamp.
// ----------------------------------------------------------------------------
module sft_norm #(
    parameter int FRAC_BITS = sft_pkg::FRAC_BITS_DEF,
    parameter int CW        = sft_pkg::TW,
    parameter int SIDE_W    = 1
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [CW-1:0]          in_c [3],
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic signed [sft_pkg::DW-1:0] out_r [3],
    output logic                          out_zero,
    output logic [SIDE_W-1:0]             out_side
);
    import sft_pkg::*;

    localparam int KW    = $clog2(CW);
    localparam int NW    = NB + FRAC_BITS + NORM_SH + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int CTX_W = SIDE_W + 3 + 3 * NB + 1;
    localparam logic [DW-1:0] LIM = (FRAC_BITS >= DW - 1) ?
                                    {1'b0, {(DW-1){1'b1}}} : (DW'(1) << FRAC_BITS);

    // ---------------- stage a: magnitudes
    logic              a_v_reg;
    logic [CW-1:0]     a_mag_reg [3];
    logic [2:0]        a_neg_reg;
    logic [SIDE_W-1:0] a_side_reg;

    // ---------------- stage b: shift amount
    logic              b_v_reg;
    logic [CW-1:0]     b_mag_reg [3];
    logic [2:0]        b_neg_reg;
    logic [KW-1:0]     b_k_reg;
    logic [SIDE_W-1:0] b_side_reg;
    logic [KW-1:0]     b_k_next;

    // ---------------- stage c: reduced magnitudes
    logic              c_v_reg;
    logic [NB-1:0]     c_m_reg [3];
    logic [2:0]        c_neg_reg;
    logic              c_zero_reg;
    logic [SIDE_W-1:0] c_side_reg;

    // ---------------- stage d: squares
    logic              d_v_reg;
    logic [2*NB-1:0]   d_sq_reg [3];
    logic [CTX_W-1:0]  d_ctx_reg;

    // ---------------- square root stages
    logic [SQ_STEPS:0] sq_v_reg;
    logic [SQ_W-1:0]   sq_s_reg   [SQ_STEPS+1];
    logic [SQ_W-1:0]   sq_r_reg   [SQ_STEPS+1];
    logic [CTX_W-1:0]  sq_ctx_reg [SQ_STEPS+1];

    // ---------------- division stages
    logic [QW:0]       dv_v_reg;
    logic [NW-1:0]     dv_rem_reg  [QW+1][3];
    logic [QW-1:0]     dv_q_reg    [QW+1][3];
    logic [RT_W-1:0]   dv_root_reg [QW+1];
    logic [CTX_W-1:0]  dv_ctx_reg  [QW+1];

    logic [CW-1:0]     any_mag;

    always_comb
    begin
        any_mag  = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        b_k_next = '0;
        for (int i = NB; i < CW; i++)
        begin
            if (any_mag[i])
            begin
                b_k_next = KW'(i - NB + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
            d_v_reg  <= 1'b0;
            sq_v_reg <= '0;
            dv_v_reg <= '0;
        end
        else
        begin
            a_v_reg  <= in_valid;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
            d_v_reg  <= c_v_reg;
            sq_v_reg <= {sq_v_reg[SQ_STEPS-1:0], d_v_reg};
            dv_v_reg <= {dv_v_reg[QW-1:0], sq_v_reg[SQ_STEPS]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_neg_reg[i] <= in_c[i][CW-1];
            a_mag_reg[i] <= in_c[i][CW-1] ? CW'(-in_c[i]) : CW'(in_c[i]);
            b_mag_reg[i] <= a_mag_reg[i];
            c_m_reg[i]   <= NB'(b_mag_reg[i] >> b_k_reg);
            d_sq_reg[i]  <= (2*NB)'(c_m_reg[i]) * (2*NB)'(c_m_reg[i]);
        end
        a_side_reg <= in_side;
        b_neg_reg  <= a_neg_reg;
        b_k_reg    <= b_k_next;
        b_side_reg <= a_side_reg;
        c_neg_reg  <= b_neg_reg;
        c_zero_reg <= (b_mag_reg[0] | b_mag_reg[1] | b_mag_reg[2]) == '0;
        c_side_reg <= b_side_reg;
        d_ctx_reg  <= {c_side_reg, c_neg_reg, c_m_reg[2], c_m_reg[1], c_m_reg[0],
                       c_zero_reg};
        // sum of squares scaled by 2^NB feeds the root
        sq_s_reg[0]   <= (SQ_W'(d_sq_reg[0]) + SQ_W'(d_sq_reg[1]) +
                          SQ_W'(d_sq_reg[2])) << NB;
        sq_r_reg[0]   <= '0;
        sq_ctx_reg[0] <= d_ctx_reg;
    end

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            logic [SQ_W-1:0] s_in;
            logic [SQ_W:0]   trial;
            logic [SQ_W-1:0] s_next;
            logic [SQ_W-1:0] r_next;

            always_comb
            begin
                s_in  = sq_s_reg[k];
                trial = {1'b0, sq_r_reg[k]} + {1'b0, BIT};
                if ({1'b0, s_in} >= trial)
                begin
                    s_next = s_in - trial[SQ_W-1:0];
                    r_next = (sq_r_reg[k] >> 1) + BIT;
                end
                else
                begin
                    s_next = s_in;
                    r_next = sq_r_reg[k] >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                sq_s_reg[k+1]   <= s_next;
                sq_r_reg[k+1]   <= r_next;
                sq_ctx_reg[k+1] <= sq_ctx_reg[k];
            end
        end
    endgenerate

    // ---------------- numerators: m * 2^(FRAC_BITS+NORM_SH) + root/2
    logic [RT_W-1:0] root;
    logic [NB-1:0]   sq_m [3];
    assign root = sq_r_reg[SQ_STEPS][RT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_m[i] = sq_ctx_reg[SQ_STEPS][1 + i*NB +: NB];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_reg[0][i] <= (NW'(sq_m[i]) << (FRAC_BITS + NORM_SH)) + NW'(root >> 1);
            dv_q_reg[0][i]   <= '0;
        end
        dv_root_reg[0] <= root;
        dv_ctx_reg[0]  <= sq_ctx_reg[SQ_STEPS];
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++)
        begin : g_div
            localparam int QB = QW - 1 - j;
            logic [NW-1:0] dsh;
            logic [NW-1:0] rem_next [3];
            logic [QW-1:0] q_next   [3];

            always_comb
            begin
                dsh = NW'(dv_root_reg[j]) << QB;
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = dv_rem_reg[j][i];
                    q_next[i]   = dv_q_reg[j][i];
                    if (dv_rem_reg[j][i] >= dsh)
                    begin
                        rem_next[i]   = dv_rem_reg[j][i] - dsh;
                        q_next[i][QB] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[j+1][i] <= rem_next[i];
                    dv_q_reg[j+1][i]   <= q_next[i];
                end
                dv_root_reg[j+1] <= dv_root_reg[j];
                dv_ctx_reg[j+1]  <= dv_ctx_reg[j];
            end
        end
    endgenerate

    // ---------------- sign, clamp, register out
    logic [CTX_W-1:0] fin_ctx;
    logic             fin_zero;
    logic [2:0]       fin_neg;
    assign fin_ctx  = dv_ctx_reg[QW];
    assign fin_zero = fin_ctx[0];
    assign fin_neg  = fin_ctx[1 + 3*NB +: 3];

    logic                 o_v_reg;
    logic signed [DW-1:0] o_r_reg [3];
    logic                 o_zero_reg;
    logic [SIDE_W-1:0]    o_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_r_reg[i] <= fin_zero ? '0 :
                          sign_sat(MAG_W'(dv_q_reg[QW][i]), fin_neg[i], LIM);
        end
        o_zero_reg <= fin_zero;
        o_side_reg <= fin_ctx[CTX_W-1 -: SIDE_W];
    end

    assign out_valid = o_v_reg;
    assign out_r     = o_r_reg;
    assign out_zero  = o_zero_reg;
    assign out_side  = o_side_reg;

endmodule

// File: src/sft_frame.sv
// ----------------------------------------------------------------------------
// sft_frame
// Bitangent from normal x tangent, then projection of the vector onto the
// frame (op 0) or recombination from the frame (op 1).
// ----------------------------------------------------------------------------
module sft_frame #(
    parameter int FRAC_BITS = sft_pkg::FRAC_BITS_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  sft_pkg::vec_t                  in_t,
    input  logic                           in_zero,
    input  sft_pkg::in_ctx_t               in_ctx,
    output logic                           out_valid,
    output logic signed [sft_pkg::RRW-1:0] out_rr [3],
    output sft_pkg::out_ctx_t              out_ctx
);
    import sft_pkg::*;

    localparam int PW = 2 * DW;
    localparam logic [DW-1:0] LIM = (FRAC_BITS >= DW - 1) ?
                                    {1'b0, {(DW-1){1'b1}}} : (DW'(1) << FRAC_BITS);
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic op;
        vec_t n;
        vec_t v;
        vec_t t;
        logic zero;
    } fctx_t;

    logic [4:0]           v_reg;
    fctx_t                c0_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    logic signed [PW-1:0] cp_reg [6];
    logic signed [PW:0]   df_reg [3];
    vec_t                 b2_reg, b3_reg, b4_reg;
    logic signed [PW-1:0] pr_reg [3][3];
    logic signed [RRW-1:0] rr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // round half away from zero, drop FRAC_BITS, clamp
    function automatic logic signed [DW-1:0] reduce(input logic signed [PW:0] p);
        logic [MAG_W-1:0] m;
        m = p[PW] ? MAG_W'(-p) : MAG_W'(p);
        m = (m + HALF) >> FRAC_BITS;
        return sign_sat(m, p[PW], LIM);
    endfunction

    logic signed [DW-1:0] fr [3][3];
    logic signed [DW-1:0] vv [3];
    logic signed [DW-1:0] sel [3][3];

    always_comb
    begin
        fr[0][0] = c2_reg.t.x; fr[0][1] = c2_reg.t.y; fr[0][2] = c2_reg.t.z;
        fr[1][0] = b2_reg.x;   fr[1][1] = b2_reg.y;   fr[1][2] = b2_reg.z;
        fr[2][0] = c2_reg.n.x; fr[2][1] = c2_reg.n.y; fr[2][2] = c2_reg.n.z;
        vv[0] = c2_reg.v.x; vv[1] = c2_reg.v.y; vv[2] = c2_reg.v.z;
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sel[i][c] = c2_reg.op ? fr[c][i] : fr[i][c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg    <= '{op: in_ctx.op, n: in_ctx.n, v: in_ctx.v, t: in_t, zero: in_zero};
        cp_reg[0] <= in_ctx.n.y * in_t.z;
        cp_reg[1] <= in_ctx.n.z * in_t.y;
        cp_reg[2] <= in_ctx.n.z * in_t.x;
        cp_reg[3] <= in_ctx.n.x * in_t.z;
        cp_reg[4] <= in_ctx.n.x * in_t.y;
        cp_reg[5] <= in_ctx.n.y * in_t.x;

        c1_reg    <= c0_reg;
        df_reg[0] <= (PW+1)'(cp_reg[0]) - (PW+1)'(cp_reg[1]);
        df_reg[1] <= (PW+1)'(cp_reg[2]) - (PW+1)'(cp_reg[3]);
        df_reg[2] <= (PW+1)'(cp_reg[4]) - (PW+1)'(cp_reg[5]);

        c2_reg   <= c1_reg;
        b2_reg.x <= reduce(df_reg[0]);
        b2_reg.y <= reduce(df_reg[1]);
        b2_reg.z <= reduce(df_reg[2]);

        c3_reg <= c2_reg;
        b3_reg <= b2_reg;
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pr_reg[i][c] <= vv[c] * sel[i][c];
            end
        end

        c4_reg <= c3_reg;
        b4_reg <= b3_reg;
        for (int i = 0; i < 3; i++)
        begin
            rr_reg[i] <= RRW'(pr_reg[i][0]) + RRW'(pr_reg[i][1]) + RRW'(pr_reg[i][2]);
        end
    end

    assign out_valid    = v_reg[4];
    assign out_rr       = rr_reg;
    assign out_ctx.t    = c4_reg.t;
    assign out_ctx.b    = b4_reg;
    assign out_ctx.zero = c4_reg.zero;

endmodule

// File: src/shading_frame_transform_core.sv
// ----------------------------------------------------------------------------
// shading_frame_transform_core
// Builds a tangent frame around a normal and moves a vector between world
// and local space; outputs tangent, bitangent and the normalized result.
// ----------------------------------------------------------------------------
// Path from start to done: raw tangent register, tangent normalizer, frame stages,
// result normalizer, output register; most of it lies in the two bit-per-stage root/divide chains.
// Throughput: one beat per cycle; busy stays low, done pulses once per beat.
// Reset: rst_n clears every valid bit at once; beats in flight are dropped.
module shading_frame_transform_core #(
    parameter int FRAC_BITS = sft_pkg::FRAC_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic signed [sft_pkg::DW-1:0] normal_x,
    input  logic signed [sft_pkg::DW-1:0] normal_y,
    input  logic signed [sft_pkg::DW-1:0] normal_z,
    input  logic signed [sft_pkg::DW-1:0] vec_x,
    input  logic signed [sft_pkg::DW-1:0] vec_y,
    input  logic signed [sft_pkg::DW-1:0] vec_z,
    output logic                          done,
    output logic signed [sft_pkg::DW-1:0] tangent_x,
    output logic signed [sft_pkg::DW-1:0] tangent_y,
    output logic signed [sft_pkg::DW-1:0] tangent_z,
    output logic signed [sft_pkg::DW-1:0] bitangent_x,
    output logic signed [sft_pkg::DW-1:0] bitangent_y,
    output logic signed [sft_pkg::DW-1:0] bitangent_z,
    output logic signed [sft_pkg::DW-1:0] out_x,
    output logic signed [sft_pkg::DW-1:0] out_y,
    output logic signed [sft_pkg::DW-1:0] out_z,
    output logic                          degenerate
);
    import sft_pkg::*;

    localparam int NORM_LAT = 5 + SQ_STEPS + 1 + (FRAC_BITS + 1) + 1;
    localparam int LAT      = 1 + NORM_LAT + 5 + NORM_LAT + 1;
    localparam int LIM_I    = (FRAC_BITS >= DW - 1) ? 32767 : (1 << FRAC_BITS);

    assign busy = 1'b0;

    // ---------------- raw tangent
    logic                 t0_v_reg;
    logic signed [TW-1:0] tr_reg [3];
    in_ctx_t              t0_ctx_reg;
    logic                 eq;

    assign eq = (normal_x == normal_y) && (normal_x == normal_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
        end
        else
        begin
            t0_v_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_reg[0] <= TW'(normal_z) - TW'(normal_y);
        tr_reg[1] <= eq ? TW'(normal_x) + TW'(normal_z) : TW'(normal_x) - TW'(normal_z);
        tr_reg[2] <= eq ? -TW'(normal_y) - TW'(normal_x) : TW'(normal_y) - TW'(normal_x);
        t0_ctx_reg <= '{op: op,
                        n: '{x: normal_x, y: normal_y, z: normal_z},
                        v: '{x: vec_x, y: vec_y, z: vec_z}};
    end

    // ---------------- tangent normalize
    logic                 n1_valid;
    logic signed [DW-1:0] n1_t [3];
    logic                 n1_zero;
    in_ctx_t              n1_ctx;

    sft_norm #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (TW),
        .SIDE_W    ($bits(in_ctx_t))
    ) u_norm_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t0_v_reg),
        .in_c      (tr_reg),
        .in_side   (t0_ctx_reg),
        .out_valid (n1_valid),
        .out_r     (n1_t),
        .out_zero  (n1_zero),
        .out_side  (n1_ctx)
    );

    // ---------------- frame and transform
    vec_t                  n1_tv;
    logic                  fr_valid;
    logic signed [RRW-1:0] fr_rr [3];
    out_ctx_t              fr_ctx;

    assign n1_tv = '{x: n1_t[0], y: n1_t[1], z: n1_t[2]};

    sft_frame #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n1_valid),
        .in_t      (n1_tv),
        .in_zero   (n1_zero),
        .in_ctx    (n1_ctx),
        .out_valid (fr_valid),
        .out_rr    (fr_rr),
        .out_ctx   (fr_ctx)
    );

    // ---------------- result normalize
    logic                 n2_valid;
    logic signed [DW-1:0] n2_r [3];
    logic                 n2_zero;
    out_ctx_t             n2_ctx;

    sft_norm #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (RRW),
        .SIDE_W    ($bits(out_ctx_t))
    ) u_norm_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_c      (fr_rr),
        .in_side   (fr_ctx),
        .out_valid (n2_valid),
        .out_r     (n2_r),
        .out_zero  (n2_zero),
        .out_side  (n2_ctx)
    );

    // ---------------- output register
    logic done_reg;
    logic deg_reg;
    vec_t t_reg, b_reg, r_reg;
    logic deg_next;

    assign deg_next = n2_zero || n2_ctx.zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= n2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= deg_next;
        t_reg   <= deg_next ? '0 : n2_ctx.t;
        b_reg   <= deg_next ? '0 : n2_ctx.b;
        r_reg   <= deg_next ? '0 : vec_t'{x: n2_r[0], y: n2_r[1], z: n2_r[2]};
    end

    assign done        = done_reg;
    assign degenerate  = deg_reg;
    assign tangent_x   = t_reg.x;
    assign tangent_y   = t_reg.y;
    assign tangent_z   = t_reg.z;
    assign bitangent_x = b_reg.x;
    assign bitangent_y = b_reg.y;
    assign bitangent_z = b_reg.z;
    assign out_x       = r_reg.x;
    assign out_y       = r_reg.y;
    assign out_z       = r_reg.z;

    // ---------------- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("beat did not complete at the pipeline latency");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching beat");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (tangent_x == 0 && tangent_y == 0 && tangent_z == 0 &&
                                  bitangent_x == 0 && out_x == 0 && out_z == 0))
        else $error("degenerate result not zeroed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(tangent_x) <= LIM_I && int'(tangent_x) >= -LIM_I &&
                  int'(out_y) <= LIM_I && int'(out_y) >= -LIM_I))
        else $error("output beyond saturation limit");

endmodule
